// ===== hdl/fmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types, codes and the control store for the Fibonacci matrix-power
// sequencer.
// ----------------------------------------------------------------------------
package fmp_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;
	localparam int unsigned UpcW  = 4;

	// operand selects
	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;
	localparam logic [1:0] SEL_T = 2'd2;

	// which 32x32 partial product of a 64x64 low product
	localparam logic [1:0] PART_LL = 2'd0;
	localparam logic [1:0] PART_LH = 2'd1;
	localparam logic [1:0] PART_HL = 2'd2;

	// jump kinds
	localparam logic [1:0] J_NEXT = 2'd0; // fall through
	localparam logic [1:0] J_BIT  = 2'd1; // fall through if exponent bit set, else end of bit
	localparam logic [1:0] J_LOOP = 2'd2; // end of bit: next bit or output
	localparam logic [1:0] J_OUT  = 2'd3; // hand result to output register

	// program addresses
	localparam logic [UpcW-1:0] UA_ADJ = 4'd0;
	localparam logic [UpcW-1:0] UA_OUT = 4'd13;

	typedef struct packed {
		logic       mul_en;  // issue a partial product
		logic [1:0] sel_x;
		logic [1:0] sel_y;
		logic [1:0] part;
		logic       clr;     // product starts a fresh sum
		logic       adj;     // t <= 2a - b
		logic       save;    // s <= acc
		logic       wb;      // a <= s, b <= acc
		logic       step;    // a <= a + b, b <= a (times base matrix)
		logic [1:0] jmp;
	} ucode_t;

	localparam ucode_t UC_NOP = '{1'b0, SEL_A, SEL_A, PART_LL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		J_NEXT};

	// Control store. One bit of the exponent per pass:
	//   a = F(k+1), b = F(k); square: a' = a*a + b*b, b' = b*(2a - b)
	function automatic ucode_t ucode_rom(input logic [UpcW-1:0] addr);
		ucode_t w;
		w = UC_NOP;
		unique case (addr)
			4'd0:  w.adj = 1'b1;
			4'd1:  w = '{1'b1, SEL_A, SEL_A, PART_LL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd2:  w = '{1'b1, SEL_A, SEL_A, PART_LH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd3:  w = '{1'b1, SEL_A, SEL_A, PART_HL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd4:  w = '{1'b1, SEL_B, SEL_B, PART_LL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd5:  w = '{1'b1, SEL_B, SEL_B, PART_LH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd6:  w = '{1'b1, SEL_B, SEL_B, PART_HL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd7:  w = '{1'b1, SEL_B, SEL_T, PART_LL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd8:  w = '{1'b1, SEL_B, SEL_T, PART_LH, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, J_NEXT};
			4'd9:  w = '{1'b1, SEL_B, SEL_T, PART_HL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, J_NEXT};
			4'd10: w = UC_NOP;                          // last product drains
			4'd11: begin
				w.wb  = 1'b1;
				w.jmp = J_BIT;
			end
			4'd12: begin
				w.step = 1'b1;
				w.jmp  = J_LOOP;
			end
			4'd13: w.jmp = J_OUT;
			default: w = UC_NOP;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/fibonacci_matrix_power.sv =====
// ----------------------------------------------------------------------------
// fibonacci_matrix_power
// Fibonacci number of an index by square-and-multiply of {{1,1},{1,0}},
// modulo 2^64, run by a microcoded sequencer around one 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel | signals                      | beat
//  --------+------------------------------+----------------------------------
//  in      | in_valid, in_ready, index    | one index to evaluate
//  out     | out_valid, out_ready,        | F(index) modulo 2^64, signed
//          | fib_value                    |
//
//  Index 0 or 1: the sequencer goes straight to the output step. Else each
//  of the INDEX_BITS bits of index-1, msb first, gets a squaring and a step
//  by the base matrix where that bit is set; the output step comes last.
//  Each squaring makes nine passes through the single 32x32 multiplier.
//  One item at a time; in_ready is high whenever the sequencer is idle, even
//  while a result waits in the output register. A stalled output holds the
//  sequencer on its last step. Reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power
	import fmp_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [INDEX_BITS-1:0]   index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [WordW-1:0] fib_value
);

	localparam int unsigned CntW = $clog2(INDEX_BITS + 1);

	// sequencer state
	logic                  busy_q;
	logic [UpcW-1:0]       upc_q;
	logic [CntW-1:0]       cnt_q;
	logic [INDEX_BITS-1:0] exp_q;
	ucode_t                uw;

	// datapath
	logic [WordW-1:0] a_q, b_q, t_q, s_q, acc_q;
	logic [WordW-1:0] opx, opy, mul_res;
	logic [HalfW-1:0] mx, my;
	logic [WordW-1:0] prod_s1;
	logic             vld_s1, hi_s1, clr_s1;

	logic             out_valid_q;
	logic [WordW-1:0] res_q;
	logic             in_fire, out_free, last_bit;

	assign uw       = ucode_rom(upc_q);
	assign in_ready = !busy_q;
	assign in_fire  = in_valid && !busy_q;
	assign out_free = !out_valid_q || out_ready;
	assign last_bit = (cnt_q == '0);

	assign out_valid = out_valid_q;
	assign fib_value = $signed(res_q);

	// operand selection
	always_comb begin
		unique case (uw.sel_x)
			SEL_B:   opx = b_q;
			SEL_T:   opx = t_q;
			default: opx = a_q;
		endcase
		unique case (uw.sel_y)
			SEL_B:   opy = b_q;
			SEL_T:   opy = t_q;
			default: opy = a_q;
		endcase
		unique case (uw.part)
			PART_LH: begin
				mx = opx[HalfW-1:0];
				my = opy[WordW-1:HalfW];
			end
			PART_HL: begin
				mx = opx[WordW-1:HalfW];
				my = opy[HalfW-1:0];
			end
			default: begin
				mx = opx[HalfW-1:0];
				my = opy[HalfW-1:0];
			end
		endcase
	end

	assign mul_res = {{HalfW{1'b0}}, mx} * {{HalfW{1'b0}}, my};

	// multiplier output stage, control rides along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= busy_q && uw.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_res;
		hi_s1   <= (uw.part != PART_LL);
		clr_s1  <= uw.clr;
	end

	// accumulator: cross terms land in the upper half only
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) +
				(hi_s1 ? {prod_s1[HalfW-1:0], {HalfW{1'b0}}} : prod_s1);
		end
	end

	// working pair and temporaries
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (index <= INDEX_BITS'(1)) begin
				a_q <= WordW'(index);
			end else begin
				a_q <= WordW'(1);
			end
			b_q <= '0;
		end else if (busy_q) begin
			if (uw.adj) begin
				t_q <= (a_q << 1) - b_q;
			end
			if (uw.save) begin
				s_q <= acc_q;
			end
			if (uw.wb) begin
				a_q <= s_q;
				b_q <= acc_q;
			end
			if (uw.step) begin
				a_q <= a_q + b_q;
				b_q <= a_q;
			end
		end
	end

	// exponent shifts out msb first
	always_ff @(posedge clk) begin
		if (in_fire) begin
			exp_q <= index - INDEX_BITS'(1);
		end else if (busy_q && ((uw.jmp == J_LOOP) ||
				(uw.jmp == J_BIT && !exp_q[INDEX_BITS-1]))) begin
			exp_q <= exp_q << 1;
		end
	end

	// step counter and jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			upc_q       <= UA_ADJ;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: load on the output step, drop once taken
			if (busy_q && uw.jmp == J_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				busy_q <= 1'b1;
				if (index <= INDEX_BITS'(1)) begin
					upc_q <= UA_OUT;
					cnt_q <= '0;
				end else begin
					upc_q <= UA_ADJ;
					cnt_q <= CntW'(INDEX_BITS - 1);
				end
			end else if (busy_q) begin
				unique case (uw.jmp)
					J_NEXT: upc_q <= upc_q + UpcW'(1);
					J_BIT, J_LOOP: begin
						if (uw.jmp == J_BIT && exp_q[INDEX_BITS-1]) begin
							upc_q <= upc_q + UpcW'(1);
						end else if (last_bit) begin
							upc_q <= UA_OUT;
						end else begin
							cnt_q <= cnt_q - CntW'(1);
							upc_q <= UA_ADJ;
						end
					end
					J_OUT: begin
						if (out_free) begin
							busy_q <= 1'b0;
						end
					end
					default: upc_q <= upc_q;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (busy_q && uw.jmp == J_OUT && out_free) begin
			res_q <= a_q;
		end
	end

	// checks
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (upc_q <= UA_OUT))
		else $error("sequencer left the program");

	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && upc_q == UA_OUT) |-> (cnt_q == '0))
		else $error("result step reached with exponent bits left");

	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> busy_q)
		else $error("product in flight while idle");

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q && upc_q == UA_OUT))
		else $error("result raised outside the output step");

endmodule
